FILE: rtl/core/scb_pkg.sv
// Shared types and constants of the scanline span coverage buffer.
package scb_pkg;

  localparam int COL_W  = 10;
  localparam int LINE_W = 10;
  localparam int WORD_W = 64;
  localparam int WIDX_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LEFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_RIGHT = 1'b1;

  localparam logic [COL_W-1:0] VIEW_LEFT_RST  = 10'd0;
  localparam logic [COL_W-1:0] VIEW_RIGHT_RST = 10'd1023;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_TEST   = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_FULL   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [LINE_W-1:0]  line_index;
    logic [COL_W-1:0]   span_first;
    logic [COL_W-1:0]   span_last;
  } in_t;

  typedef struct packed {
    logic visible;
    logic line_full;
  } out_t;

  typedef struct packed {
    kind_t             kind;
    logic [COL_W-1:0]  span_lo;
    logic [COL_W-1:0]  span_hi;
    logic [COL_W-1:0]  view_lo;
    logic [COL_W-1:0]  view_hi;
  } word_ctl_t;

  typedef struct packed {
    logic hit;
    logic gap;
  } word_res_t;

endpackage

FILE: rtl/core/scb_word.sv
// Read-modify-write logic for one 64-bit coverage word.
module scb_word (
  input  scb_pkg::word_ctl_t              ctl,
  input  logic [scb_pkg::WIDX_W-1:0]      word_idx,
  input  logic [scb_pkg::WORD_W-1:0]      row,
  output logic [scb_pkg::WORD_W-1:0]      row_new,
  output scb_pkg::word_res_t              res
);

  // Bits of this word that lie inside the inclusive column range [lo, hi].
  function automatic logic [scb_pkg::WORD_W-1:0] range_mask(
    input logic [scb_pkg::WIDX_W-1:0] w,
    input logic [scb_pkg::COL_W-1:0]  lo,
    input logic [scb_pkg::COL_W-1:0]  hi
  );
    logic [5:0] l;
    logic [5:0] h;
    if (lo > hi || hi[9:6] < w || lo[9:6] > w) begin
      return '0;
    end
    l = (lo[9:6] == w) ? lo[5:0] : 6'd0;
    h = (hi[9:6] == w) ? hi[5:0] : 6'd63;
    return ({scb_pkg::WORD_W{1'b1}} >> (6'd63 - h)) & ({scb_pkg::WORD_W{1'b1}} << l);
  endfunction

  logic [scb_pkg::WORD_W-1:0] span_mask;
  logic [scb_pkg::WORD_W-1:0] view_mask;
  logic                       span_op;

  assign span_op   = (ctl.kind == scb_pkg::KIND_TEST) || (ctl.kind == scb_pkg::KIND_INSERT);
  assign span_mask = span_op ? range_mask(word_idx, ctl.span_lo, ctl.span_hi) : '0;
  assign view_mask = range_mask(word_idx, ctl.view_lo, ctl.view_hi);

  always_comb begin
    case (ctl.kind)
      scb_pkg::KIND_CLEAR:  row_new = '0;
      scb_pkg::KIND_FULL:   row_new = '1;
      scb_pkg::KIND_INSERT: row_new = row | span_mask;
      default:              row_new = row;
    endcase
  end

  assign res.hit = |(~row & span_mask);
  assign res.gap = |(~row_new & view_mask);

endmodule

FILE: rtl/core/scanline_span_coverage_buffer_top.sv
// Top level of the scanline span coverage buffer: control, coverage memory and ports.
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    in_data   (scb_pkg::in_t)
//  out_     output     out_valid / out_ready  out_data  (scb_pkg::out_t)
//  cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item on a valid line goes from IDLE to RUN, which walks the EW stored 64-bit words
// of the line (16 by default), then to FIN and back to IDLE; in RUN the
// coverage memory reads one word and writes one back per cycle. A line at or beyond LINES
// goes straight to FIN and never touches the memory. After reset a clearing pass zeroes all
// LINES * 2**WB words with in_ready low; cfg_ready is always high.
// A result waiting in the output register holds the next item in FIN, which also stalls input.
module scanline_span_coverage_buffer_top #(
  parameter int LINES       = 1024,
  parameter int LINE_PIXELS = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  scb_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output scb_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scb_pkg::COL_W-1:0]        cfg_data
);

  // Column fields are 10 bits wide, so no more than sixteen words of a line can ever
  // be addressed; words past that are not stored at all.
  localparam int WPL   = (LINE_PIXELS + 63) / 64;
  localparam int EW    = (WPL > 16) ? 16 : WPL;
  localparam int WB    = (EW > 1) ? $clog2(EW) : 1;
  localparam int LB    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int AW    = LB + WB;
  localparam int DEPTH = LINES * (1 << WB);

  localparam logic [WB-1:0] LAST_WORD = WB'(EW - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [scb_pkg::COL_W-1:0] COL_MAX =
    (LINE_PIXELS - 1 > 1023) ? 10'd1023 : 10'(LINE_PIXELS - 1);

  typedef enum logic [1:0] {
    ST_CLR,
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t                        st_r, st_nxt;
  logic [AW-1:0]                 clr_addr_r, clr_addr_nxt;
  logic [scb_pkg::COL_W-1:0]     view_left_r, view_left_nxt;
  logic [scb_pkg::COL_W-1:0]     view_right_r, view_right_nxt;
  scb_pkg::kind_t                kind_r, kind_nxt;
  logic [LB-1:0]                 line_r, line_nxt;
  logic [scb_pkg::COL_W-1:0]     lo_r, lo_nxt;
  logic [scb_pkg::COL_W-1:0]     hi_r, hi_nxt;
  logic [WB-1:0]                 rd_w_r, rd_w_nxt;
  logic                          rd_busy_r, rd_busy_nxt;
  logic                          dv_r, dv_nxt;
  logic [WB-1:0]                 dw_r, dw_nxt;
  logic                          vis_r, vis_nxt;
  logic                          full_r, full_nxt;
  logic                          out_valid_r, out_valid_nxt;
  scb_pkg::out_t                 out_r, out_nxt;

  logic [scb_pkg::WORD_W-1:0]    mem [DEPTH];
  logic [scb_pkg::WORD_W-1:0]    mem_rdata_r;
  logic                          mem_we;
  logic                          mem_re;
  logic [AW-1:0]                 mem_wa;
  logic [AW-1:0]                 mem_ra;
  logic [scb_pkg::WORD_W-1:0]    mem_wd;

  logic [scb_pkg::COL_W-1:0]     view_hi;
  logic                          bad_line;
  logic                          in_xfer;
  scb_pkg::word_ctl_t            wctl;
  scb_pkg::word_res_t            wres;
  logic [scb_pkg::WORD_W-1:0]    row_new;

  assign in_ready  = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_xfer   = in_valid && in_ready;
  assign bad_line  = int'(in_data.line_index) >= LINES;

  // The usable window ends at the right view edge or at the end of the line.
  assign view_hi = (view_right_r > COL_MAX) ? COL_MAX : view_right_r;

  assign wctl.kind    = kind_r;
  assign wctl.span_lo = lo_r;
  assign wctl.span_hi = hi_r;
  assign wctl.view_lo = view_left_r;
  assign wctl.view_hi = view_hi;

  scb_word u_word (
    .ctl      (wctl),
    .word_idx (scb_pkg::WIDX_W'(dw_r)),
    .row      (mem_rdata_r),
    .row_new  (row_new),
    .res      (wres)
  );

  // Reads run one word ahead of the write-back, so a word is never read and written
  // in the same cycle and no forwarding is needed.
  assign mem_re = (st_r == ST_RUN) && rd_busy_r;
  assign mem_ra = {line_r, rd_w_r};
  assign mem_we = (st_r == ST_CLR) || ((st_r == ST_RUN) && dv_r);
  assign mem_wa = (st_r == ST_CLR) ? clr_addr_r : {line_r, dw_r};
  assign mem_wd = (st_r == ST_CLR) ? '0 : row_new;

  always_comb begin
    st_nxt         = st_r;
    clr_addr_nxt   = clr_addr_r;
    view_left_nxt  = view_left_r;
    view_right_nxt = view_right_r;
    kind_nxt       = kind_r;
    line_nxt       = line_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    rd_w_nxt       = rd_w_r;
    rd_busy_nxt    = rd_busy_r;
    dv_nxt         = 1'b0;
    dw_nxt         = dw_r;
    vis_nxt        = vis_r;
    full_nxt       = full_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scb_pkg::CFG_VIEW_LEFT:  view_left_nxt  = cfg_data;
        scb_pkg::CFG_VIEW_RIGHT: view_right_nxt = cfg_data;
        default: ;
      endcase
    end

    case (st_r)
      ST_CLR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          kind_nxt    = in_data.kind;
          line_nxt    = LB'(in_data.line_index);
          lo_nxt      = (in_data.span_first > view_left_r) ? in_data.span_first : view_left_r;
          hi_nxt      = (in_data.span_last < view_hi) ? in_data.span_last : view_hi;
          rd_w_nxt    = '0;
          rd_busy_nxt = 1'b1;
          vis_nxt     = 1'b0;
          if (bad_line) begin
            full_nxt = 1'b0;
            st_nxt   = ST_FIN;
          end else begin
            full_nxt = 1'b1;
            st_nxt   = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (rd_busy_r) begin
          dv_nxt = 1'b1;
          dw_nxt = rd_w_r;
          if (rd_w_r == LAST_WORD) begin
            rd_busy_nxt = 1'b0;
          end else begin
            rd_w_nxt = rd_w_r + 1'b1;
          end
        end
        if (dv_r) begin
          vis_nxt  = vis_r || wres.hit;
          full_nxt = full_r && !wres.gap;
          if (dw_r == LAST_WORD) begin
            st_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.visible   = vis_r;
          out_nxt.line_full = full_r;
          out_valid_nxt     = 1'b1;
          st_nxt            = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_CLR;
      clr_addr_r   <= '0;
      view_left_r  <= scb_pkg::VIEW_LEFT_RST;
      view_right_r <= scb_pkg::VIEW_RIGHT_RST;
      rd_busy_r    <= 1'b0;
      dv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      clr_addr_r   <= clr_addr_nxt;
      view_left_r  <= view_left_nxt;
      view_right_r <= view_right_nxt;
      rd_busy_r    <= rd_busy_nxt;
      dv_r         <= dv_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    kind_r <= kind_nxt;
    line_r <= line_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    rd_w_r <= rd_w_nxt;
    dw_r   <= dw_nxt;
    vis_r  <= vis_nxt;
    full_r <= full_nxt;
    out_r  <= out_nxt;
  end

  // Coverage memory: one write port, one read port, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_ra];
    end
  end

  // The write-back never lands on the word being read in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("coverage memory read and write hit the same word");

  // While both stages are busy, the read stage is exactly one word ahead.
  a_read_leads_write: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN && dv_r && rd_busy_r) |-> (rd_w_r == dw_r + 1'b1))
    else $error("read and write-back word indexes out of step");

  // A line out of range skips the memory and goes straight to the result.
  a_bad_line_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && bad_line) |=> (st_r == ST_FIN && !vis_r && !full_r))
    else $error("out-of-range line did not produce an empty result");

endmodule

FILE: bench/scanline_span_coverage_buffer_top_tb.sv
// Self-checking testbench for the scanline span coverage buffer top level.
module scanline_span_coverage_buffer_top_tb;

  localparam int LINES        = 1024;
  localparam int LINE_PIXELS  = 1024;
  localparam int WORDS        = (LINE_PIXELS + 63) / 64;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 160;
  // Long enough to cover any item on a valid line and any result still in flight.
  localparam int SETTLE_CYCLES = 40;
  // Watchdog bound on the slowest legal run, including the clearing pass after reset.
  localparam int CYCLE_LIMIT  = 1000000;

  // Shadow of the coverage memory and the view window. Every accepted operation
  // is applied here in order, and its outcome is queued for the result channel.
  class coverage_tracker;
    bit [63:0]     covered_bits [LINES][WORDS];
    int            view_lo = scb_pkg::VIEW_LEFT_RST;
    int            view_hi = scb_pkg::VIEW_RIGHT_RST;
    scb_pkg::out_t outcome_q [$];
    int            errors = 0;

    function void set_view(logic [scb_pkg::CFG_IDX_W-1:0] index,
                           logic [scb_pkg::COL_W-1:0] data);
      if (index == scb_pkg::CFG_VIEW_LEFT) view_lo = data;
      else view_hi = data;
    endfunction

    // Bits of word w that fall inside the inclusive column range [lo, hi].
    function bit [63:0] word_mask(int w, int lo, int hi);
      int base, l, h;
      base = w * 64;
      if (lo > hi || hi < base || lo > base + 63) return '0;
      l = (lo > base) ? lo - base : 0;
      h = (hi < base + 63) ? hi - base : 63;
      return ({64{1'b1}} >> (63 - h)) & ({64{1'b1}} << l);
    endfunction

    function int window_top();
      return (view_hi > LINE_PIXELS - 1) ? LINE_PIXELS - 1 : view_hi;
    endfunction

    function bit row_full(int row);
      for (int w = 0; w < WORDS; w++)
        if ((~covered_bits[row][w] & word_mask(w, view_lo, window_top())) != 0) return 1'b0;
      return 1'b1;
    endfunction

    function void apply_op(scb_pkg::in_t op);
      scb_pkg::out_t res;
      int            row, lo, hi;
      bit [63:0]     m;
      res = '0;
      row = op.line_index;
      if (row < LINES) begin
        case (op.kind)
          scb_pkg::KIND_CLEAR: for (int w = 0; w < WORDS; w++) covered_bits[row][w] = '0;
          scb_pkg::KIND_FULL:  for (int w = 0; w < WORDS; w++) covered_bits[row][w] = '1;
          default: begin
            lo = (op.span_first > view_lo) ? op.span_first : view_lo;
            hi = (op.span_last < window_top()) ? op.span_last : window_top();
            for (int w = 0; w < WORDS; w++) begin
              m = word_mask(w, lo, hi);
              if ((~covered_bits[row][w] & m) != 0) res.visible = 1'b1;
              if (op.kind == scb_pkg::KIND_INSERT) covered_bits[row][w] |= m;
            end
          end
        endcase
        res.line_full = row_full(row);
      end
      outcome_q.push_back(res);
    endfunction

    function void check_outcome(scb_pkg::out_t got);
      scb_pkg::out_t want;
      if (outcome_q.size() == 0) begin
        errors++;
        $error("result with no operation pending: visible %0b line_full %0b",
               got.visible, got.line_full);
        return;
      end
      want = outcome_q.pop_front();
      if (got.visible !== want.visible) begin
        errors++;
        $error("visible: expected %0b, got %0b", want.visible, got.visible);
      end
      if (got.line_full !== want.line_full) begin
        errors++;
        $error("line_full: expected %0b, got %0b", want.line_full, got.line_full);
      end
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction
  endclass

  // Every input of the block holds a known value from time zero, reset asserted.
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  scb_pkg::in_t                  in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  scb_pkg::out_t                 out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [scb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [scb_pkg::COL_W-1:0]     cfg_data = '0;

  coverage_tracker tracker = new();

  // Stimulus-side view of the window, used to aim spans near its edges.
  int cur_left = scb_pkg::VIEW_LEFT_RST;
  int cur_right = scb_pkg::VIEW_RIGHT_RST;
  int items_sent = 0;
  int in_calm = 0;
  int out_calm = 0;
  int cycles = 0;
  int line_pool [4];
  int phase_left [PHASES] = '{100, 0, 1023, 0, 600, 37, 512, -1, -1, 0};
  int phase_right [PHASES] = '{227, 1023, 1023, 0, 200, 900, 575, -1, -1, 1023};

  scanline_span_coverage_buffer_top #(
    .LINES       (LINES),
    .LINE_PIXELS (LINE_PIXELS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // All transfers are observed here, on values as they stood at the clock edge.
  // A result is checked before a transfer in the same cycle is applied, so a
  // result can never be matched against its own operation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) tracker.check_outcome(out_data);
      if (cfg_valid && cfg_ready) tracker.set_view(cfg_index, cfg_data);
      if (in_valid && in_ready) tracker.apply_op(in_data);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("scanline_span_coverage_buffer_top verification failed");
      $finish;
    end
  end

  // Idle time before a transfer: mostly drawn at random, with stretches of none.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic int clip(int v);
    return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
  endfunction

  // The receiver stalls a random number of cycles before each result, then
  // holds ready high until that result has been taken.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Valid stays high from one item to the next when no idle time is drawn, so
  // it is never lowered and raised in the same time step.
  task automatic send_op(input scb_pkg::kind_t kind, input int line, input int first,
                         input int last);
    scb_pkg::in_t item;
    int           gap;
    item.kind       = kind;
    item.line_index = scb_pkg::LINE_W'(line);
    item.span_first = scb_pkg::COL_W'(first);
    item.span_last  = scb_pkg::COL_W'(last);
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Both view registers are written in back-to-back transfers while the block is idle.
  task automatic write_view(input int left, input int right);
    cfg_valid <= 1'b1;
    cfg_index <= scb_pkg::CFG_VIEW_LEFT;
    cfg_data  <= scb_pkg::COL_W'(left);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= scb_pkg::CFG_VIEW_RIGHT;
    cfg_data  <= scb_pkg::COL_W'(right);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_left  = left;
    cur_right = right;
  endtask

  task automatic wait_idle();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Spans are mostly aimed at the window and its edges, with some fully
  // random ones and some deliberately reversed (empty) ranges.
  function automatic void pick_span(output int first, output int last);
    int r, lo_c, hi_c;
    r = $urandom_range(0, 99);
    lo_c = (cur_left < cur_right) ? cur_left : cur_right;
    hi_c = (cur_left < cur_right) ? cur_right : cur_left;
    if (r < 10) begin
      first = $urandom_range(0, 1023);
      last  = $urandom_range(0, 1023);
    end else if (r < 15) begin
      first = $urandom_range(1, 1023);
      last  = $urandom_range(0, first - 1);
    end else begin
      first = clip(int'($urandom_range(0, hi_c - lo_c + 16)) + lo_c - 8);
      last  = clip(first + (($urandom_range(0, 99) < 70) ? int'($urandom_range(0, 63))
                                                         : int'($urandom_range(0, 1023))));
    end
  endfunction

  // A well-formed fill of one line: clear it, then cover the window with
  // overlapping inserts from left to right, probing ahead now and then. The
  // last insert should make the line report full.
  task automatic sweep_line(input int line);
    int cursor, chunk;
    send_op(scb_pkg::KIND_CLEAR, line, $urandom_range(0, 1023), $urandom_range(0, 1023));
    cursor = clip(cur_left - int'($urandom_range(0, 4)));
    while (cursor <= cur_right) begin
      chunk = $urandom_range(1, 160);
      if ($urandom_range(0, 3) == 0)
        send_op(scb_pkg::KIND_TEST, line, cursor, clip(cursor + chunk + 4));
      send_op(scb_pkg::KIND_INSERT, line, cursor, clip(cursor + chunk - 1));
      cursor = cursor + ((chunk > 2) ? chunk - int'($urandom_range(0, 2)) : chunk);
    end
    send_op(scb_pkg::KIND_TEST, line, cur_left, cur_right);
  endtask

  task automatic random_op();
    int r, line, first, last;
    r = $urandom_range(0, 99);
    line = line_pool[$urandom_range(0, 3)];
    pick_span(first, last);
    if (r < 6) send_op(scb_pkg::KIND_CLEAR, line, first, last);
    else if (r < 10) send_op(scb_pkg::KIND_FULL, line, first, last);
    else if (r < 14) sweep_line(line);
    else if (r < 22)
      send_op(scb_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 1023));
    else if (r < 55) send_op(scb_pkg::KIND_TEST, line, first, last);
    else send_op(scb_pkg::KIND_INSERT, line, first, last);
  endtask

  initial begin
    int target, left, right;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset window. These wait out the clearing pass.
    send_op(scb_pkg::KIND_TEST,   0, 0, 1023);      // whole fresh line is visible
    send_op(scb_pkg::KIND_INSERT, 0, 0, 0);         // first column
    send_op(scb_pkg::KIND_INSERT, 0, 1023, 1023);   // last column
    send_op(scb_pkg::KIND_INSERT, 0, 600, 400);     // reversed range: no effect
    send_op(scb_pkg::KIND_TEST,   0, 0, 1);
    send_op(scb_pkg::KIND_INSERT, 0, 63, 64);       // straddles a word boundary
    send_op(scb_pkg::KIND_TEST,   0, 63, 64);
    send_op(scb_pkg::KIND_INSERT, 0, 1, 1022);      // completes the line
    send_op(scb_pkg::KIND_TEST,   0, 0, 1023);
    send_op(scb_pkg::KIND_CLEAR,  0, 1023, 0);
    send_op(scb_pkg::KIND_FULL,   1023, 1023, 1023);
    send_op(scb_pkg::KIND_TEST,   1023, 0, 1023);
    send_op(scb_pkg::KIND_INSERT, 1023, 5, 9);
    send_op(scb_pkg::KIND_CLEAR,  1023, 0, 0);
    send_op(scb_pkg::KIND_INSERT, 1023, 0, 1023);   // one span covers the whole line
    send_op(scb_pkg::KIND_TEST,   682, 341, 682);
    send_op(scb_pkg::KIND_INSERT, 341, 682, 341);
    send_op(scb_pkg::KIND_INSERT, 682, 0, 1023);
    send_op(scb_pkg::KIND_TEST,   0, 0, 1023);

    // Random phases, each under its own view window. Reversed windows and
    // one-column windows at both ends are among them.
    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      wait_idle();
      left  = phase_left[p];
      right = phase_right[p];
      if (left < 0) begin
        left  = $urandom_range(0, 1023);
        right = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1023))
                                            : clip(left + int'($urandom_range(0, 300)));
      end
      write_view(left, right);
      foreach (line_pool[i])
        line_pool[i] = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 1023)
                                                   : int'($urandom_range(0, 1023));
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_op();
    end

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("scanline_span_coverage_buffer_top verification clean");
    else
      $display("scanline_span_coverage_buffer_top verification failed");
    $finish;
  end

endmodule
